FILE: rtl/matrix_product_with_gradient_unit_macros.svh
// Assertion macros for the matrix product unit.
`ifndef MATRIX_PRODUCT_WITH_GRADIENT_UNIT_MACROS_SVH
`define MATRIX_PRODUCT_WITH_GRADIENT_UNIT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define MPGU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define MPGU_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MPGU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define MPGU_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/mpgu_pkg.sv
// Shared types and constants of the matrix product unit.
package mpgu_pkg;

   localparam int OP_W      = 2;
   localparam int IDX_W     = 4;
   localparam int DATA_W    = 32;
   localparam int DIM_W     = 5;
   localparam int CSR_IDX_W = 2;
   localparam int PROD_W    = 64;
   localparam int ACC_W     = 72;
   localparam int RND_W     = ACC_W - 16;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_A  = 2'd0,
      OP_LOAD_B  = 2'd1,
      OP_COMPUTE = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_ROWS      = 2'd0,
      CSR_INNER_LEN     = 2'd1,
      CSR_NUM_COLS      = 2'd2,
      CSR_GRADIENT_MODE = 2'd3
   } csr_type;

   // tag that rides along with each operand pair through the pipeline
   typedef struct packed {
      logic             first;
      logic             last;
      logic             last_col;
      logic [IDX_W-1:0] col;
   } tag_type;

endpackage

FILE: rtl/mpgu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mpgu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             write_enable,
   input  logic [AW-1:0]    write_addr,
   input  logic [WIDTH-1:0] write_data,
   input  logic [AW-1:0]    read_addr,
   output logic [WIDTH-1:0] read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

FILE: rtl/matrix_product_with_gradient_unit.sv
// Top level of the Q16.16 dense matrix product unit with gradient mode.
//
// Load items (operation 0 or 1) write one element in the cycle they are taken and leave
// busy low, so loads can come every cycle while no compute item holds busy. A compute
// item holds busy high while it forms outer results of len products each, where outer is
// the number of result elements (num_cols, or inner_len in gradient mode) and len the dot
// length (inner_len, or num_cols in gradient mode): each operand store has one read port,
// so one product enters the multiply-accumulate pipeline per cycle, and read, multiply,
// accumulate and rounding add four register stages behind the last product. Each result
// strobes once its last product has passed these stages; busy drops in the cycle that
// carries the last result of the row, so the next item can be taken at the edge that
// ends it. Results cannot be held off by the receiver. Compute items for a row outside
// num_rows and unused operation codes are dropped.
`include "matrix_product_with_gradient_unit_macros.svh"

module matrix_product_with_gradient_unit import mpgu_pkg::*; #(
   parameter int MAX_DIM     = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [OP_W-1:0]          req_operation,
   input  logic [IDX_W-1:0]         req_row_index,
   input  logic [IDX_W-1:0]         req_col_index,
   input  logic signed [DATA_W-1:0] req_element_value,
   output logic                     rsp_strobe,
   output logic [IDX_W-1:0]         rsp_result_row,
   output logic [IDX_W-1:0]         rsp_result_col,
   output logic signed [DATA_W-1:0] rsp_result_value,
   output logic                     rsp_last_of_row,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DIM_W-1:0]         csr_write_data
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int VW_EFF = (VALUE_WIDTH > DATA_W) ? DATA_W : VALUE_WIDTH;
   localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(32768);
   localparam logic signed [RND_W-1:0] SAT_MAX =
      {{(RND_W - VW_EFF + 1){1'b0}}, {(VW_EFF - 1){1'b1}}};
   localparam logic signed [RND_W-1:0] SAT_MIN = ~SAT_MAX;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   // size register as used: zero acts as one, above MAX_DIM acts as MAX_DIM
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] d;
      if (v == '0) begin
         d = DIM_W'(1);
      end else if (int'(v) > MAX_DIM) begin
         d = DIM_W'(MAX_DIM);
      end else begin
         d = v;
      end
      return d;
   endfunction

   // configuration registers
   logic [DIM_W-1:0] num_rows_ff, inner_len_ff, num_cols_ff;
   logic             gradient_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff      <= DIM_W'(16);
         inner_len_ff     <= DIM_W'(16);
         num_cols_ff      <= DIM_W'(16);
         gradient_mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_NUM_ROWS:      num_rows_ff      <= csr_write_data;
            CSR_INNER_LEN:     inner_len_ff     <= csr_write_data;
            CSR_NUM_COLS:      num_cols_ff      <= csr_write_data;
            CSR_GRADIENT_MODE: gradient_mode_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   logic [DIM_W-1:0] nr, nk, nc, a_col_bound;
   logic [DIM_W-1:0] row_ext, col_ext;

   assign nr          = eff_dim(num_rows_ff);
   assign nk          = eff_dim(inner_len_ff);
   assign nc          = eff_dim(num_cols_ff);
   assign a_col_bound = gradient_mode_ff ? nc : nk;
   assign row_ext     = {1'b0, req_row_index};
   assign col_ext     = {1'b0, req_col_index};

   state_type        state_ff;
   logic             accept, compute_go, a_we, b_we;
   logic [ADDR_W-1:0] wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start & ~busy;
   assign a_we       = accept && (req_operation == OP_LOAD_A) &&
                       (row_ext < nr) && (col_ext < a_col_bound);
   assign b_we       = accept && (req_operation == OP_LOAD_B) &&
                       (row_ext < nk) && (col_ext < nc);
   assign compute_go = accept && (req_operation == OP_COMPUTE) && (row_ext < nr);
   assign wr_addr    = ADDR_W'(int'(req_row_index) * MAX_DIM + int'(req_col_index));
   assign wr_data    = VALUE_WIDTH'($unsigned(req_element_value));

   // row sequencer
   logic [IDX_W-1:0] row_ff;
   logic [DIM_W-1:0] outer_ff, len_ff, x_ff, y_ff;
   logic             mode_run_ff;
   logic             s3_valid_ff;
   tag_type          s3_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         x_ff     <= '0;
         y_ff     <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (compute_go) begin
                  row_ff      <= req_row_index;
                  outer_ff    <= gradient_mode_ff ? nk : nc;
                  len_ff      <= gradient_mode_ff ? nc : nk;
                  mode_run_ff <= gradient_mode_ff;
                  x_ff        <= '0;
                  y_ff        <= '0;
                  state_ff    <= ST_ISSUE;
               end
            end
            ST_ISSUE: begin
               if (y_ff == len_ff - DIM_W'(1)) begin
                  y_ff <= '0;
                  if (x_ff == outer_ff - DIM_W'(1)) begin
                     state_ff <= ST_DRAIN;
                  end else begin
                     x_ff <= x_ff + DIM_W'(1);
                  end
               end else begin
                  y_ff <= y_ff + DIM_W'(1);
               end
            end
            ST_DRAIN: begin
               // last result of the row enters the output register at this edge
               if (s3_valid_ff && s3_tag_ff.last_col) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   logic [ADDR_W-1:0] a_rd_addr, b_rd_addr;
   logic              issue_valid;
   tag_type           issue_tag;

   assign a_rd_addr = ADDR_W'(int'(row_ff) * MAX_DIM + int'(y_ff));
   assign b_rd_addr = mode_run_ff ? ADDR_W'(int'(x_ff) * MAX_DIM + int'(y_ff))
                                  : ADDR_W'(int'(y_ff) * MAX_DIM + int'(x_ff));
   assign issue_valid        = (state_ff == ST_ISSUE);
   assign issue_tag.first    = (y_ff == '0);
   assign issue_tag.last     = (y_ff == len_ff - DIM_W'(1));
   assign issue_tag.last_col = (x_ff == outer_ff - DIM_W'(1));
   assign issue_tag.col      = x_ff[IDX_W-1:0];

   logic [VALUE_WIDTH-1:0] a_q, b_q;

   mpgu_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_first_store (
      .clock        (clock),
      .write_enable (a_we),
      .write_addr   (wr_addr),
      .write_data   (wr_data),
      .read_addr    (a_rd_addr),
      .read_data    (a_q)
   );

   mpgu_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_second_store (
      .clock        (clock),
      .write_enable (b_we),
      .write_addr   (wr_addr),
      .write_data   (wr_data),
      .read_addr    (b_rd_addr),
      .read_data    (b_q)
   );

   // stage 1: store data arrives, multiply
   logic                     s1_valid_ff;
   tag_type                  s1_tag_ff;
   logic signed [VW_EFF-1:0] a_low, b_low;
   logic signed [DATA_W-1:0] a_op, b_op;
   logic signed [PROD_W-1:0] prod_in;

   assign a_low   = a_q[VW_EFF-1:0];
   assign b_low   = b_q[VW_EFF-1:0];
   assign a_op    = DATA_W'(a_low);
   assign b_op    = DATA_W'(b_low);
   assign prod_in = PROD_W'(a_op) * PROD_W'(b_op);

   // stage 2: product register; stage 3: accumulator
   logic                     s2_valid_ff;
   tag_type                  s2_tag_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, prod_ext;

   assign prod_ext = ACC_W'(prod_ff);
   assign acc_in   = s2_tag_ff.first ? prod_ext : acc_ff + prod_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         s1_valid_ff <= issue_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff && s2_tag_ff.last;
         if (s2_valid_ff) begin
            acc_ff <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_tag_ff <= issue_tag;
      s2_tag_ff <= s1_tag_ff;
      prod_ff   <= prod_in;
      s3_tag_ff <= s2_tag_ff;
   end

   // stage 4: round half up to Q16.16, saturate
   logic signed [ACC_W-1:0] acc_round;
   logic signed [RND_W-1:0] rnd, sat_in;

   assign acc_round = acc_ff + HALF_LSB;
   assign rnd       = RND_W'(acc_round >>> 16);

   always_comb begin
      if (rnd > SAT_MAX) begin
         sat_in = SAT_MAX;
      end else if (rnd < SAT_MIN) begin
         sat_in = SAT_MIN;
      end else begin
         sat_in = rnd;
      end
   end

   logic                     rsp_strobe_ff, rsp_last_ff;
   logic [IDX_W-1:0]         rsp_row_ff, rsp_col_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_valid_ff) begin
         rsp_row_ff   <= row_ff;
         rsp_col_ff   <= s3_tag_ff.col;
         rsp_value_ff <= DATA_W'(sat_in);
         rsp_last_ff  <= s3_tag_ff.last_col;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_result_row   = rsp_row_ff;
   assign rsp_result_col   = rsp_col_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_last_of_row  = rsp_last_ff;

   `MPGU_ASSERT_NXT(a_compute_busy, clock, reset, compute_go, busy, "compute transfer did not raise busy")
   `MPGU_ASSERT_IMP(a_mid_row_busy, clock, reset, rsp_strobe && !rsp_last_of_row, busy, "busy dropped before end of row")
   `MPGU_ASSERT_IMP(a_inflight_busy, clock, reset, s3_valid_ff, state_ff != ST_IDLE, "result in flight while idle")
   `MPGU_ASSERT_NXT(a_row_gap, clock, reset, rsp_strobe && rsp_last_of_row, !rsp_strobe, "result after end of row")

endmodule
